// ===== hw/rtl/hmsf_pkg.sv =====
package hmsf_pkg;

  // Field widths
  localparam int COL_W  = 6;
  localparam int ROW_W  = 12;
  localparam int HGT_W  = 16;
  localparam int DIV_W  = 10;
  localparam int SUM_W  = 22;
  localparam int WGT_W  = 4;
  localparam int TAP_W  = 4;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int MAX_COLS_DEF = 62;

  // Register reset values
  localparam logic [COL_W-1:0] GRID_COLS_RST    = 6'd41;
  localparam logic [ROW_W-1:0] GRID_ROWS_RST    = 12'd41;
  localparam logic [HGT_W-1:0] BORDER_LEVEL_RST = 16'd2176;
  localparam logic [DIV_W-1:0] DIVISOR_RST      = 10'd23;

  // Kernel weights
  localparam logic [WGT_W-1:0] W_CENTRE = 4'd12;
  localparam logic [WGT_W-1:0] W_EDGE   = 4'd6;
  localparam logic [WGT_W-1:0] W_CORNER = 4'd5;

  // Last tap of the 3x3 window, taps scanned top-left to bottom-right
  localparam logic [TAP_W-1:0] LAST_TAP = 4'd8;
  localparam logic [TAP_W-1:0] TAP_END  = 4'd9;

  typedef enum logic [1:0] {
    REG_GRID_COLS,
    REG_GRID_ROWS,
    REG_BORDER_LEVEL,
    REG_DIVISOR
  } reg_idx_t;

  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } off_t;

  // Effective configuration, special values already folded in
  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [HGT_W-1:0] border;
    logic [DIV_W-1:0] divisor;
  } cfg_t;

  function automatic off_t tap_row_off(input logic [TAP_W-1:0] t);
    off_t o;
    case (t)
      4'd0, 4'd1, 4'd2: o = OFF_NEG;
      4'd3, 4'd4, 4'd5: o = OFF_ZERO;
      default:          o = OFF_POS;
    endcase
    return o;
  endfunction

  function automatic off_t tap_col_off(input logic [TAP_W-1:0] t);
    off_t o;
    case (t)
      4'd0, 4'd3, 4'd6: o = OFF_NEG;
      4'd1, 4'd4, 4'd7: o = OFF_ZERO;
      default:          o = OFF_POS;
    endcase
    return o;
  endfunction

  function automatic logic [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] t);
    logic [WGT_W-1:0] w;
    case (t)
      4'd4:                   w = W_CENTRE;
      4'd1, 4'd3, 4'd5, 4'd7: w = W_EDGE;
      default:                w = W_CORNER;
    endcase
    return w;
  endfunction

  // Row number mod 3: fold base-4 digits, since 4 = 1 mod 3
  function automatic logic [1:0] mod3(input logic [ROW_W-1:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < ROW_W / 2; i++) begin
      s1 = s1 + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

endpackage

// ===== hw/rtl/hmsf_ifs.sv =====
interface hmsf_in_if;
  logic                       valid;
  logic                       ready;
  logic [hmsf_pkg::HGT_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

interface hmsf_out_if;
  logic                       valid;
  logic                       ready;
  logic [hmsf_pkg::SUM_W-1:0] smoothed_height;
  logic [hmsf_pkg::ROW_W-1:0] out_row;
  logic [hmsf_pkg::COL_W-1:0] out_col;
  logic                       grid_done;

  modport source (output valid, output smoothed_height, output out_row, output out_col,
                  output grid_done, input ready);
  modport sink (input valid, input smoothed_height, input out_row, input out_col,
                input grid_done, output ready);
endinterface

// ===== hw/rtl/hmsf_cfg.sv =====
module hmsf_cfg #(
  parameter int MAX_COLS = hmsf_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmsf_pkg::ADDR_W-1:0] paddr,
  input  logic [hmsf_pkg::DATA_W-1:0] pwdata,
  output logic [hmsf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output hmsf_pkg::cfg_t              cfg_eff
);

  localparam logic [hmsf_pkg::COL_W-1:0] MAX_COLS_C = hmsf_pkg::COL_W'(MAX_COLS);

  logic [hmsf_pkg::COL_W-1:0] grid_cols_r;
  logic [hmsf_pkg::ROW_W-1:0] grid_rows_r;
  logic [hmsf_pkg::HGT_W-1:0] border_level_r;
  logic [hmsf_pkg::DIV_W-1:0] divisor_r;
  hmsf_pkg::reg_idx_t         idx;
  logic                       wr_en;

  assign pready = 1'b1;
  assign idx    = hmsf_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Hold the register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r    <= hmsf_pkg::GRID_COLS_RST;
      grid_rows_r    <= hmsf_pkg::GRID_ROWS_RST;
      border_level_r <= hmsf_pkg::BORDER_LEVEL_RST;
      divisor_r      <= hmsf_pkg::DIVISOR_RST;
    end else if (wr_en) begin
      unique case (idx)
        hmsf_pkg::REG_GRID_COLS:    grid_cols_r    <= pwdata[hmsf_pkg::COL_W-1:0];
        hmsf_pkg::REG_GRID_ROWS:    grid_rows_r    <= pwdata[hmsf_pkg::ROW_W-1:0];
        hmsf_pkg::REG_BORDER_LEVEL: border_level_r <= pwdata[hmsf_pkg::HGT_W-1:0];
        hmsf_pkg::REG_DIVISOR:      divisor_r      <= pwdata[hmsf_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register value
  always_comb begin
    unique case (idx)
      hmsf_pkg::REG_GRID_COLS:    prdata = hmsf_pkg::DATA_W'(grid_cols_r);
      hmsf_pkg::REG_GRID_ROWS:    prdata = hmsf_pkg::DATA_W'(grid_rows_r);
      hmsf_pkg::REG_BORDER_LEVEL: prdata = hmsf_pkg::DATA_W'(border_level_r);
      hmsf_pkg::REG_DIVISOR:      prdata = hmsf_pkg::DATA_W'(divisor_r);
      default:                    prdata = '0;
    endcase
  end

  // Fold zero settings and an oversize column count into usable values
  always_comb begin
    if (grid_cols_r == '0) begin
      cfg_eff.cols = hmsf_pkg::COL_W'(1);
    end else if (grid_cols_r > MAX_COLS_C) begin
      cfg_eff.cols = MAX_COLS_C;
    end else begin
      cfg_eff.cols = grid_cols_r;
    end
    cfg_eff.rows    = (grid_rows_r == '0) ? hmsf_pkg::ROW_W'(1) : grid_rows_r;
    cfg_eff.border  = border_level_r;
    cfg_eff.divisor = (divisor_r == '0) ? hmsf_pkg::DIV_W'(1) : divisor_r;
  end

endmodule

// ===== hw/rtl/hmsf_div.sv =====
module hmsf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hmsf_pkg::SUM_W-1:0] dividend,
  input  logic [hmsf_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [hmsf_pkg::SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(hmsf_pkg::SUM_W + 1);

  logic [hmsf_pkg::DIV_W-1:0] rem_r;
  logic [hmsf_pkg::SUM_W-1:0] quo_r;
  logic [hmsf_pkg::DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [hmsf_pkg::DIV_W:0]   shifted;
  logic                       fits;
  logic [hmsf_pkg::DIV_W:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[hmsf_pkg::SUM_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[hmsf_pkg::SUM_W-2:0], fits};
      rem_r <= fits ? diff[hmsf_pkg::DIV_W-1:0] : shifted[hmsf_pkg::DIV_W-1:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(hmsf_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !$past(start)) |-> rem_r < dsr_r) else $error("partial remainder out of range");

endmodule

// ===== hw/rtl/hmsf_core.sv =====
module hmsf_core #(
  parameter int MAX_COLS = hmsf_pkg::MAX_COLS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hmsf_pkg::cfg_t cfg_eff,
  hmsf_in_if.sink        in_chan,
  hmsf_out_if.source     out_chan
);

  localparam int DEPTH = 3 * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = hmsf_pkg::HGT_W + hmsf_pkg::WGT_W;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_GATHER,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    JOB_UPPER_LEFT,
    JOB_UPPER_LAST,
    JOB_FLUSH
  } job_t;

  // Row store: three rows, row k of the grid in slot k mod 3
  logic [hmsf_pkg::HGT_W-1:0] mem [DEPTH];

  state_t                     state_r, state_nxt;
  job_t                       job_r, job_nxt;
  logic [hmsf_pkg::ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [hmsf_pkg::COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [hmsf_pkg::ROW_W-1:0] r_r, r_nxt;
  logic [hmsf_pkg::COL_W-1:0] c_r, c_nxt;
  logic [1:0]                 slot_r, slot_nxt;
  logic                       last_r, last_nxt;
  logic [hmsf_pkg::COL_W-1:0] k_r, k_nxt;
  logic [hmsf_pkg::ROW_W-1:0] er_r, er_nxt;
  logic [hmsf_pkg::COL_W-1:0] ec_r, ec_nxt;
  logic [1:0]                 eslot_r, eslot_nxt;
  logic                       edone_r, edone_nxt;
  logic [hmsf_pkg::TAP_W-1:0] tap_r, tap_nxt;
  logic [hmsf_pkg::SUM_W-1:0] acc_r, acc_nxt;
  logic                       prev_inb_r, prev_inb_nxt;
  logic [hmsf_pkg::WGT_W-1:0] prev_w_r, prev_w_nxt;
  logic [hmsf_pkg::HGT_W-1:0] rd_data_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [hmsf_pkg::SUM_W-1:0] out_height_r, out_height_nxt;
  logic [hmsf_pkg::ROW_W-1:0] out_row_r, out_row_nxt;
  logic [hmsf_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic                       out_done_r, out_done_nxt;

  logic [hmsf_pkg::ROW_W-1:0] rows_m1;
  logic [hmsf_pkg::COL_W-1:0] cols_m1;
  logic [hmsf_pkg::ROW_W-1:0] r_in;
  logic [hmsf_pkg::COL_W-1:0] c_in;
  logic                       in_acc;
  logic [AW-1:0]              wr_addr;
  logic [1:0]                 slot_up;
  hmsf_pkg::off_t             roff, coff;
  logic                       row_ok, col_ok;
  logic [1:0]                 tslot;
  logic [hmsf_pkg::COL_W-1:0] tcol;
  logic [AW-1:0]              rd_addr;
  logic [hmsf_pkg::HGT_W-1:0] tap_val;
  logic [PW-1:0]              term;
  logic                       div_start;
  logic                       div_done;
  logic [hmsf_pkg::SUM_W-1:0] div_quo;

  assign rows_m1 = cfg_eff.rows - hmsf_pkg::ROW_W'(1);
  assign cols_m1 = cfg_eff.cols - hmsf_pkg::COL_W'(1);

  // Clamp the position into a grid that may have shrunk
  assign r_in    = (row_pos_r > rows_m1) ? rows_m1 : row_pos_r;
  assign c_in    = (col_pos_r > cols_m1) ? cols_m1 : col_pos_r;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign wr_addr = AW'(hmsf_pkg::mod3(r_in)) * ROW_STRIDE + AW'(c_in);

  // Slot of the row above the current one
  assign slot_up = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;

  // Tap address and bounds for the window position in tap_r
  always_comb begin
    roff = hmsf_pkg::tap_row_off(tap_r);
    coff = hmsf_pkg::tap_col_off(tap_r);
    case (roff)
      hmsf_pkg::OFF_NEG: begin
        row_ok = er_r != '0;
        tslot  = (eslot_r == 2'd0) ? 2'd2 : eslot_r - 2'd1;
      end
      hmsf_pkg::OFF_POS: begin
        row_ok = er_r != rows_m1;
        tslot  = (eslot_r == 2'd2) ? 2'd0 : eslot_r + 2'd1;
      end
      default: begin
        row_ok = 1'b1;
        tslot  = eslot_r;
      end
    endcase
    case (coff)
      hmsf_pkg::OFF_NEG: begin
        col_ok = ec_r != '0;
        tcol   = ec_r - hmsf_pkg::COL_W'(1);
      end
      hmsf_pkg::OFF_POS: begin
        col_ok = ec_r != cols_m1;
        tcol   = ec_r + hmsf_pkg::COL_W'(1);
      end
      default: begin
        col_ok = 1'b1;
        tcol   = ec_r;
      end
    endcase
    rd_addr = AW'(tslot) * ROW_STRIDE + AW'(tcol);
  end

  // Weight the previous tap: one read of the store per cycle
  assign tap_val = prev_inb_r ? rd_data_r : cfg_eff.border;
  assign term    = PW'(tap_val) * PW'(prev_w_r);

  // Write on accept, read one tap per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wr_addr] <= in_chan.height_sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer: pick each result cell, gather its window, divide, deliver
  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    row_pos_nxt    = row_pos_r;
    col_pos_nxt    = col_pos_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    slot_nxt       = slot_r;
    last_nxt       = last_r;
    k_nxt          = k_r;
    er_nxt         = er_r;
    ec_nxt         = ec_r;
    eslot_nxt      = eslot_r;
    edone_nxt      = edone_r;
    tap_nxt        = tap_r;
    acc_nxt        = acc_r;
    prev_inb_nxt   = prev_inb_r;
    prev_w_nxt     = prev_w_r;
    out_valid_nxt  = out_valid_r;
    out_height_nxt = out_height_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_done_nxt   = out_done_r;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          r_nxt     = r_in;
          c_nxt     = c_in;
          slot_nxt  = hmsf_pkg::mod3(r_in);
          last_nxt  = (r_in == rows_m1) && (c_in == cols_m1);
          job_nxt   = JOB_UPPER_LEFT;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        tap_nxt = '0;
        acc_nxt = '0;
        unique case (job_r)
          JOB_UPPER_LEFT: begin
            job_nxt = JOB_UPPER_LAST;
            if (r_r != '0 && c_r != '0) begin
              er_nxt    = r_r - hmsf_pkg::ROW_W'(1);
              ec_nxt    = c_r - hmsf_pkg::COL_W'(1);
              eslot_nxt = slot_up;
              edone_nxt = 1'b0;
              state_nxt = S_GATHER;
            end
          end
          JOB_UPPER_LAST: begin
            job_nxt = JOB_FLUSH;
            k_nxt   = '0;
            if (r_r != '0 && c_r == cols_m1) begin
              er_nxt    = r_r - hmsf_pkg::ROW_W'(1);
              ec_nxt    = c_r;
              eslot_nxt = slot_up;
              edone_nxt = 1'b0;
              state_nxt = S_GATHER;
            end
          end
          default: begin
            if (last_r && k_r < cfg_eff.cols) begin
              er_nxt    = r_r;
              ec_nxt    = k_r;
              eslot_nxt = slot_r;
              edone_nxt = k_r == cols_m1;
              k_nxt     = k_r + hmsf_pkg::COL_W'(1);
              state_nxt = S_GATHER;
            end else begin
              // Advance the raster position, wrap after the last cell
              if (c_r == cols_m1) begin
                col_pos_nxt = '0;
                row_pos_nxt = (r_r == rows_m1) ? '0 : r_r + hmsf_pkg::ROW_W'(1);
              end else begin
                col_pos_nxt = c_r + hmsf_pkg::COL_W'(1);
                row_pos_nxt = r_r;
              end
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_GATHER: begin
        if (tap_r != '0) begin
          acc_nxt = acc_r + hmsf_pkg::SUM_W'(term);
        end
        prev_inb_nxt = row_ok && col_ok;
        prev_w_nxt   = hmsf_pkg::tap_weight(tap_r);
        if (tap_r == hmsf_pkg::TAP_END) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          tap_nxt = tap_r + hmsf_pkg::TAP_W'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_height_nxt = div_quo;
          out_row_nxt    = er_r;
          out_col_nxt    = ec_r;
          out_done_nxt   = edone_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_PICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    r_r          <= r_nxt;
    c_r          <= c_nxt;
    slot_r       <= slot_nxt;
    last_r       <= last_nxt;
    k_r          <= k_nxt;
    er_r         <= er_nxt;
    ec_r         <= ec_nxt;
    eslot_r      <= eslot_nxt;
    edone_r      <= edone_nxt;
    tap_r        <= tap_nxt;
    acc_r        <= acc_nxt;
    prev_inb_r   <= prev_inb_nxt;
    prev_w_r     <= prev_w_nxt;
    out_height_r <= out_height_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_done_r   <= out_done_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_UPPER_LEFT;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  hmsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .divisor  (cfg_eff.divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_chan.ready            = state_r == S_IDLE;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.smoothed_height = out_height_r;
  assign out_chan.out_row         = out_row_r;
  assign out_chan.out_col         = out_col_r;
  assign out_chan.grid_done       = out_done_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready) else $error("request taken while busy");
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result shown outside delivery");
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GATHER |-> tap_r <= hmsf_pkg::TAP_END) else $error("tap counter overran");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("quotient arrived outside divide");

endmodule

// ===== hw/rtl/heightmap_smoothing_filter.sv =====
// Channel   Dir  Handshake       Payload
// in_chan   in   valid/ready     height_sample[15:0]
// out_chan  out  valid/ready     smoothed_height[21:0], out_row[11:0], out_col[5:0], grid_done
// cfg       in   APB, pready=1   grid_cols, grid_rows, border_level, divisor at 0x0..0xC
//
// For each result of the row above and each flushed result, the sequencer picks the cell,
// reads the 3x3 window through the single row store read port, runs the 22-step restoring
// divider and hands the result over once the output is ready. The flushing last sample of a
// grid causes up to grid_cols + 2 results, and a sample may cause none. in_chan is ready
// only between requests. A stalled result holds the sequencer. Reset (rst_n, synchronous)
// clears the position and restores the register defaults; the row store is not cleared.
module heightmap_smoothing_filter #(
  parameter int MAX_COLS = hmsf_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hmsf_in_if.sink                     in_chan,
  hmsf_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmsf_pkg::ADDR_W-1:0] paddr,
  input  logic [hmsf_pkg::DATA_W-1:0] pwdata,
  output logic [hmsf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  hmsf_pkg::cfg_t cfg_eff;

  hmsf_cfg #(
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_eff (cfg_eff)
  );

  hmsf_core #(
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_eff  (cfg_eff),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
